// ----- hdl/hse_pkg.sv -----
`default_nettype none

package hse_pkg;

  localparam int BYTE_W           = 8;
  localparam int SYM_W            = 8;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int PEND_W           = 7;
  localparam int PCNT_W           = 3;
  localparam int ACC_W            = CODE_W + PEND_W;
  localparam int BUF_W            = 40;
  localparam int OCNT_W           = 3;
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              final_symbol;
  } sym_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } byte_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } table_entry_t;

  typedef struct packed {
    logic              load;
    logic [BUF_W-1:0]  data;
    logic [OCNT_W-1:0] count;
    logic              last;
  } emit_load_t;

  typedef struct packed {
    logic busy;
    logic flush;
    logic pend_empty;
  } pack_stat_t;

endpackage

`default_nettype wire

// ----- hdl/hse_table.sv -----
`default_nettype none

module hse_table import hse_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire sym_item_t    req,
  output table_entry_t      entry
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] LEN_LIMIT =
    (MAX_CODE_LEN > CODE_W) ? LEN_W'(CODE_W) : LEN_W'(MAX_CODE_LEN);

  table_entry_t            mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid;
  table_entry_t            raw;
  logic                    hit;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic             wr_en;
  logic             rd_en;
  logic [LEN_W-1:0] sat_len;

  assign in_range = {1'b0, req.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx      = req.symbol[IDX_W-1:0];
  assign wr_en    = accept && (req.opcode == OP_LOAD) && in_range;
  assign rd_en    = accept && (req.opcode == OP_ENCODE);
  assign sat_len  = (req.code_length > LEN_LIMIT) ? LEN_LIMIT : req.code_length;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= '{code: req.code_bits, len: sat_len};
    end
    if (rd_en) begin
      raw <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[idx] <= 1'b1;
      end
      if (rd_en) begin
        hit <= in_range && valid[idx];
      end
    end
  end

  assign entry = hit ? raw : '0;

endmodule

`default_nettype wire

// ----- hdl/hse_pack.sv -----
`default_nettype none

module hse_pack import hse_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         final_in,
  input  wire table_entry_t entry,
  input  wire logic         emit_free,
  output emit_load_t        ld,
  output pack_stat_t        stat
);

  logic              busy_valid;
  logic              final_flag;
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;

  logic              go;
  logic [CODE_W:0]   cmask;
  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [2:0]        rem;
  logic [LEN_W-1:0]  sh;
  logic [BUF_W-1:0]  word;
  logic [BYTE_W-1:0] rmask;
  logic              has_tail;
  logic [OCNT_W-1:0] count;
  logic [PEND_W-1:0] pend_bits_next;

  always_comb begin
    go             = busy_valid && emit_free;
    cmask          = ((CODE_W + 1)'(1) << entry.len) - (CODE_W + 1)'(1);
    code_m         = entry.code & cmask[CODE_W-1:0];
    acc            = (ACC_W'(pend_bits) << entry.len) | ACC_W'(code_m);
    total          = LEN_W'(pend_cnt) + entry.len;
    rem            = total[2:0];
    sh             = LEN_W'(BUF_W) - total;
    word           = BUF_W'(acc) << sh;
    rmask          = (BYTE_W'(1) << rem) - BYTE_W'(1);
    pend_bits_next = acc[PEND_W-1:0] & rmask[PEND_W-1:0];
    has_tail       = final_flag && (rem != 3'd0);
    count          = total[LEN_W-1:3] + OCNT_W'(has_tail);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      final_flag <= final_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_valid <= 1'b0;
      pend_bits  <= '0;
      pend_cnt   <= '0;
    end else begin
      busy_valid <= start || (busy_valid && !go);
      if (go) begin
        if (final_flag) begin
          pend_bits <= '0;
          pend_cnt  <= '0;
        end else begin
          pend_bits <= pend_bits_next;
          pend_cnt  <= rem;
        end
      end
    end
  end

  assign ld.load  = go;
  assign ld.data  = word;
  assign ld.count = count;
  assign ld.last  = final_flag && (count != '0);

  assign stat.busy       = busy_valid && !go;
  assign stat.flush      = go && final_flag;
  assign stat.pend_empty = (pend_cnt == '0) && (pend_bits == '0);

endmodule

`default_nettype wire

// ----- hdl/hse_emit.sv -----
`default_nettype none

module hse_emit import hse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire emit_load_t ld,
  input  wire logic       stall,
  output logic            valid,
  output byte_item_t      item,
  output logic            free
);

  logic [BUF_W-1:0]  obuf;
  logic [OCNT_W-1:0] ocnt;
  logic              olast;
  logic              take;

  assign valid = (ocnt != '0);
  assign take  = valid && !stall;
  assign free  = (ocnt == '0) || ((ocnt == OCNT_W'(1)) && take);

  assign item.out_byte = obuf[BUF_W-1 -: BYTE_W];
  assign item.last     = olast && (ocnt == OCNT_W'(1));

  always_ff @(posedge clk) begin
    if (ld.load) begin
      obuf  <= ld.data;
      olast <= ld.last;
    end else if (take) begin
      obuf <= {obuf[BUF_W-BYTE_W-1:0], BYTE_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (ld.load) begin
      ocnt <= ld.count;
    end else if (take) begin
      ocnt <= ocnt - OCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/huffman_symbol_encoder.sv -----
`default_nettype none

// Huffman encoder for 8-bit symbols with a loadable code table. A load
// transaction writes one table entry and produces no bytes; an encode
// transaction looks the symbol up and appends its code to the bit stream,
// which leaves as bytes, earliest bit in the MSB, the final byte of an image
// marked last. The table reads as empty straight after reset (one valid bit
// per entry). A symbol transaction is taken every cycle while the byte
// emitter keeps up; each encode releases n bytes (0 to 5) to the emitter,
// which sends one byte a cycle while byte_stall is low and takes the next
// encode only once it is free. The first byte of a symbol leaves after the
// table read register and then the emitter's byte buffer are loaded.
module huffman_symbol_encoder import hse_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sym_valid,
  output logic           sym_stall,
  input  wire sym_item_t sym_data,
  output logic           byte_valid,
  input  wire logic      byte_stall,
  output byte_item_t     byte_data
);

  logic         sym_accept;
  table_entry_t entry;
  emit_load_t   emit_ld;
  pack_stat_t   stat;
  logic         emit_free;

  assign sym_stall  = stat.busy;
  assign sym_accept = sym_valid && !sym_stall;

  hse_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .accept (sym_accept),
    .req    (sym_data),
    .entry  (entry)
  );

  hse_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .start     (sym_accept && (sym_data.opcode == OP_ENCODE)),
    .final_in  (sym_data.final_symbol),
    .entry     (entry),
    .emit_free (emit_free),
    .ld        (emit_ld),
    .stat      (stat)
  );

  hse_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .ld    (emit_ld),
    .stall (byte_stall),
    .valid (byte_valid),
    .item  (byte_data),
    .free  (emit_free)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_ld.load |-> emit_free)
    else $error("emitter loaded while bytes still pending");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    stat.flush |=> stat.pend_empty)
    else $error("pending bits left after final symbol");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && byte_data.last && !emit_ld.load) |=> !byte_valid)
    else $error("byte left after last transaction of the stream");

endmodule

`default_nettype wire
